### sv/lzsd_pkg.sv
// lzsd_pkg: shared types and constants of the lz token sequence decoder
// depends on nothing; imported by every module of the block except lzsd_ram
package lzsd_pkg;

  localparam int unsigned TOKEN_W     = 8;
  localparam int unsigned EXTRA_W     = 32;
  localparam int unsigned SDIST_W     = 16;
  localparam int unsigned DIST_W      = 24;
  localparam int unsigned LEN_W       = 33;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned ADDR_MAX_W  = 24;

  localparam logic [TOKEN_W-1:0] TOKEN_SHORT_MIN = 8'd32;
  localparam logic [TOKEN_W-1:0] TOKEN_EXT_MATCH = 8'd31;
  localparam logic [2:0]         LIT_ESC         = 3'd7;
  localparam logic [3:0]         MATCH_ESC       = 4'd15;
  localparam logic [LEN_W-1:0]   MATCH_BASE      = 33'd16;
  localparam logic [LEN_W-1:0]   EXT_MATCH_BASE  = 33'd47;

  typedef enum logic [1:0] {
    FUNC_TOKEN = 2'd0,
    FUNC_LIT   = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIST  = 2'd1,
    ERR_ORDER = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_COPY = 2'd1,
    CMD_ERR  = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                  kind;
    logic [7:0]            lit_byte;
    logic                  last;
    err_e                  err;
    logic [ADDR_MAX_W-1:0] waddr;
    logic [ADDR_MAX_W-1:0] raddr;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       from_match;
    logic       last_of_match;
    err_e       error;
  } res_t;

endpackage

### sv/lzsd_in_if.sv
// lzsd_in_if: valid/ready channel carrying one input item
// uses the field widths of lzsd_pkg
interface lzsd_in_if
  import lzsd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           func;
  logic [TOKEN_W-1:0]   token;
  logic [EXTRA_W-1:0]   lit_extra;
  logic [EXTRA_W-1:0]   match_extra;
  logic [SDIST_W-1:0]   short_distance;
  logic [DIST_W-1:0]    long_distance;
  logic [7:0]           literal_byte;

  modport source (
    output valid, func, token, lit_extra, match_extra, short_distance, long_distance,
           literal_byte,
    input  ready
  );
  modport sink (
    input  valid, func, token, lit_extra, match_extra, short_distance, long_distance,
           literal_byte,
    output ready
  );
endinterface

### sv/lzsd_out_if.sv
// lzsd_out_if: valid/ready channel carrying one result item
// imports lzsd_pkg; the error field is a plain two-bit vector
interface lzsd_out_if
  import lzsd_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       from_match;
  logic       last_of_match;
  logic [1:0] error;

  modport source (
    output valid, out_byte, from_match, last_of_match, error,
    input  ready
  );
  modport sink (
    input  valid, out_byte, from_match, last_of_match, error,
    output ready
  );
endinterface

### sv/lzsd_ram.sv
// lzsd_ram: generic single write port, single read port ram with registered read
// no dependencies; read during write returns the old contents
module lzsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/lzsd_cmd_fifo.sv
// lzsd_cmd_fifo: short command queue between the front and the back
// depends on lzsd_pkg for cmd_t
module lzsd_cmd_fifo
  import lzsd_pkg::*;
#(
  parameter int unsigned DEPTH = 4,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t          ent_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = ent_q[rd_ptr_q];

endmodule

### sv/lzsd_front.sv
// lzsd_front: accepts items, tracks sequence state and checks distances
// depends on lzsd_pkg and lzsd_in_if; emits one command per result to the queue
module lzsd_front
  import lzsd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 65536,
  localparam int unsigned AW          = $clog2(WINDOW_BYTES)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lzsd_in_if.sink   in_i,
  input  logic      cmd_full_i,
  output logic      cmd_valid_o,
  output cmd_t      cmd_o
);

  localparam logic [DIST_W:0] WIN = (DIST_W + 1)'(WINDOW_BYTES);

  logic [COUNT_W-1:0] produced_q, produced_d;
  logic [AW-1:0]      wpos_q, wpos_d;
  logic [DIST_W-1:0]  last_dist_q, last_dist_d;
  logic [LEN_W-1:0]   lit_left_q, lit_left_d;
  logic [LEN_W-1:0]   match_left_q, match_left_d;
  logic               armed_q, armed_d;
  logic               failed_q, failed_d;

  logic               accept;
  logic               match_pending;
  logic               dist_bad;
  logic [DIST_W:0]    wp_x;
  logic [DIST_W:0]    dist_x;
  logic [DIST_W:0]    src_x;
  logic [AW-1:0]      wpos_inc;
  logic [COUNT_W-1:0] produced_inc;
  logic [2:0]         tok_lit;
  logic [3:0]         tok_match;

  assign in_i.ready    = !cmd_full_i;
  assign accept        = in_i.valid && !cmd_full_i;
  assign match_pending = armed_q || (match_left_q != '0);

  assign wp_x   = (DIST_W + 1)'(wpos_q);
  assign dist_x = {1'b0, last_dist_q};
  assign src_x  = (wp_x >= dist_x) ? (wp_x - dist_x) : (wp_x + WIN - dist_x);

  assign dist_bad = (last_dist_q == '0) ||
                    (COUNT_W'(last_dist_q) > produced_q) ||
                    (dist_x > WIN);

  assign wpos_inc     = (wpos_q == AW'(WINDOW_BYTES - 1)) ? '0 : wpos_q + 1'b1;
  assign produced_inc = (produced_q == '1) ? produced_q : produced_q + 1'b1;
  assign tok_lit      = in_i.token[2:0];
  assign tok_match    = in_i.token[6:3];

  always_comb begin
    produced_d   = produced_q;
    wpos_d       = wpos_q;
    last_dist_d  = last_dist_q;
    lit_left_d   = lit_left_q;
    match_left_d = match_left_q;
    armed_d      = armed_q;
    failed_d     = failed_q;

    cmd_valid_o    = 1'b0;
    cmd_o.kind     = CMD_ERR;
    cmd_o.lit_byte = in_i.literal_byte;
    cmd_o.last     = 1'b0;
    cmd_o.err      = ERR_ORDER;
    cmd_o.waddr    = ADDR_MAX_W'(wpos_q);
    cmd_o.raddr    = src_x[ADDR_MAX_W-1:0];

    if (accept) begin
      if (failed_q) begin
        cmd_valid_o = 1'b1;
        cmd_o.err   = ERR_DIST;
      end else begin
        case (func_e'(in_i.func))
          FUNC_TOKEN: begin
            if (lit_left_q != '0 || match_pending) begin
              cmd_valid_o = 1'b1;
            end else begin
              armed_d = 1'b1;
              if (in_i.token >= TOKEN_SHORT_MIN) begin
                lit_left_d = (tok_lit == LIT_ESC) ?
                             (LEN_W'(in_i.lit_extra) + LEN_W'(LIT_ESC)) : LEN_W'(tok_lit);
                match_left_d = (tok_match == MATCH_ESC) ?
                               (LEN_W'(in_i.match_extra) + LEN_W'(MATCH_ESC)) :
                               LEN_W'(tok_match);
                if (!in_i.token[7]) begin
                  last_dist_d = DIST_W'(in_i.short_distance);
                end
              end else if (in_i.token < TOKEN_EXT_MATCH) begin
                lit_left_d   = '0;
                match_left_d = LEN_W'(in_i.token) + MATCH_BASE;
                last_dist_d  = in_i.long_distance;
              end else begin
                lit_left_d   = '0;
                match_left_d = LEN_W'(in_i.match_extra) + EXT_MATCH_BASE;
                last_dist_d  = in_i.long_distance;
              end
            end
          end
          FUNC_LIT: begin
            cmd_valid_o = 1'b1;
            if (lit_left_q == '0 && match_pending) begin
              cmd_o.err = ERR_ORDER;
            end else begin
              cmd_o.kind = CMD_LIT;
              cmd_o.err  = ERR_NONE;
              if (lit_left_q != '0) begin
                lit_left_d = lit_left_q - 1'b1;
              end
              wpos_d     = wpos_inc;
              produced_d = produced_inc;
            end
          end
          FUNC_TICK: begin
            if (lit_left_q != '0 || !match_pending) begin
              cmd_valid_o = 1'b1;
            end else if (armed_q && dist_bad) begin
              cmd_valid_o = 1'b1;
              cmd_o.err   = ERR_DIST;
              failed_d    = 1'b1;
            end else begin
              armed_d = 1'b0;
              if (match_left_q != '0) begin
                cmd_valid_o  = 1'b1;
                cmd_o.kind   = CMD_COPY;
                cmd_o.err    = ERR_NONE;
                cmd_o.last   = (match_left_q == LEN_W'(1));
                match_left_d = match_left_q - 1'b1;
                wpos_d       = wpos_inc;
                produced_d   = produced_inc;
              end
            end
          end
          default: begin
            cmd_valid_o = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      produced_q   <= '0;
      wpos_q       <= '0;
      last_dist_q  <= '0;
      lit_left_q   <= '0;
      match_left_q <= '0;
      armed_q      <= 1'b0;
      failed_q     <= 1'b0;
    end else begin
      produced_q   <= produced_d;
      wpos_q       <= wpos_d;
      last_dist_q  <= last_dist_d;
      lit_left_q   <= lit_left_d;
      match_left_q <= match_left_d;
      armed_q      <= armed_d;
      failed_q     <= failed_d;
    end
  end

endmodule

### sv/lzsd_back.sv
// lzsd_back: executes queued commands against the history ram, drives results
// depends on lzsd_pkg, lzsd_out_if and lzsd_ram
module lzsd_back
  import lzsd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 65536,
  localparam int unsigned AW          = $clog2(WINDOW_BYTES)
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  lzsd_out_if.source out_o
);

  localparam int unsigned ODEPTH = 2;

  cmd_t       w_cmd_q;
  logic       w_v_q;
  logic       fwd_hit_q;
  logic [7:0] fwd_data_q;
  logic [7:0] rdata;
  logic [7:0] w_data;
  logic       w_we;
  logic       issue;
  logic       re;
  res_t       w_res;

  res_t       ent_q [ODEPTH];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] ocnt_q, ocnt_d;
  logic       opop;
  logic [2:0] occ_next;

  // stage w: write history and push the result
  always_comb begin
    case (w_cmd_q.kind)
      CMD_LIT:  w_data = w_cmd_q.lit_byte;
      CMD_COPY: w_data = fwd_hit_q ? fwd_data_q : rdata;
      default:  w_data = 8'd0;
    endcase
  end

  assign w_we                = w_v_q && (w_cmd_q.kind != CMD_ERR);
  assign w_res.out_byte      = w_data;
  assign w_res.from_match    = (w_cmd_q.kind == CMD_COPY);
  assign w_res.last_of_match = (w_cmd_q.kind == CMD_COPY) && w_cmd_q.last;
  assign w_res.error         = (w_cmd_q.kind == CMD_ERR) ? w_cmd_q.err : ERR_NONE;

  // issue only when the output buffer will have room next cycle
  assign opop     = out_o.valid && out_o.ready;
  assign occ_next = 3'(ocnt_q) + 3'(w_v_q) - 3'(opop);
  assign issue    = !q_empty_i && (occ_next < 3'(ODEPTH));
  assign q_pop_o  = issue;
  assign re       = issue && (q_cmd_i.kind == CMD_COPY);

  lzsd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_cmd_q.waddr[AW-1:0]),
    .wdata_i (w_data),
    .re_i    (re),
    .raddr_i (q_cmd_i.raddr[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_v_q <= 1'b0;
    end else begin
      w_v_q <= issue;
    end
  end

  // bypass for a byte written in the same cycle as its read
  always_ff @(posedge clk_i) begin
    if (issue) begin
      w_cmd_q    <= q_cmd_i;
      fwd_hit_q  <= w_we && (w_cmd_q.waddr[AW-1:0] == q_cmd_i.raddr[AW-1:0]);
      fwd_data_q <= w_data;
    end
  end

  // output buffer
  always_comb begin
    ocnt_d = ocnt_q;
    if (w_v_q && !opop) begin
      ocnt_d = ocnt_q + 1'b1;
    end else if (!w_v_q && opop) begin
      ocnt_d = ocnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      ocnt_q   <= '0;
    end else begin
      ocnt_q <= ocnt_d;
      if (w_v_q) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (opop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (w_v_q) begin
      ent_q[wr_ptr_q] <= w_res;
    end
  end

  assign out_o.valid         = (ocnt_q != '0);
  assign out_o.out_byte      = ent_q[rd_ptr_q].out_byte;
  assign out_o.from_match    = ent_q[rd_ptr_q].from_match;
  assign out_o.last_of_match = ent_q[rd_ptr_q].last_of_match;
  assign out_o.error         = ent_q[rd_ptr_q].error;

endmodule

### sv/lz_token_sequence_decoder.sv
// lz_token_sequence_decoder: lz token stream to byte stream with a history window
// an accepted item's command is registered in the command queue, the w stage and then the output buffer
// throughput: one item per cycle while the command queue is not full, limited by the single history ram port pair
// in-order token items and zero-length matches that pass the check give no result
// reset: async active low clears all control state; history is not cleared
// depends on lzsd_pkg, lzsd_in_if, lzsd_out_if, lzsd_front, lzsd_cmd_fifo, lzsd_back
module lz_token_sequence_decoder
  import lzsd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzsd_in_if.sink     in_i,
  lzsd_out_if.source  out_o
);

  logic cmd_valid;
  cmd_t cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_cmd;

  lzsd_front #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_full_i  (q_full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  lzsd_cmd_fifo #(
    .DEPTH (4)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .cmd_i   (cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd)
  );

  lzsd_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

### sv/lzsd_checker.sv
// lzsd_checker: port-level assertions for lz_token_sequence_decoder
// depends on lzsd_pkg; bound to the top level below
module lzsd_checker
  import lzsd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       from_match_i,
  input logic       last_of_match_i,
  input logic [1:0] error_i
);

  logic seen_dist_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_dist_err_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && error_i == ERR_DIST) begin
      seen_dist_err_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(from_match_i) && $stable(last_of_match_i) && $stable(error_i))
    else $error("result changed while stalled");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && error_i != ERR_NONE |->
      out_byte_i == 8'd0 && !from_match_i && !last_of_match_i)
    else $error("error result carries data");

  a_last_is_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_of_match_i |-> from_match_i && error_i == ERR_NONE)
    else $error("last of match on a non-copy result");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_dist_err_q |-> error_i == ERR_DIST)
    else $error("result after a distance error is not a distance error");

endmodule

bind lz_token_sequence_decoder lzsd_checker u_lzsd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_byte_i      (out_o.out_byte),
  .from_match_i    (out_o.from_match),
  .last_of_match_i (out_o.last_of_match),
  .error_i         (out_o.error)
);
